// ----- design/tlbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbs_pkg: shared types and constants of the tower lamp blink sequencer
// Lamp bit positions, lamp mode codes, register indexes and the config bundle.
// ----------------------------------------------------------------------------
package tlbs_pkg;

  // Number of status entries in each mode table (at most 16 fit a register)
  localparam int StatusCount = 16;

  localparam int StatusW  = 4;
  localparam int ModesW   = 32;
  localparam int BlinkW   = 16;
  localparam int ElapsedW = BlinkW + 1;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 3;

  // Lamp word layout
  localparam int NumLamps  = 6;
  localparam int LampRed   = 0;
  localparam int LampYel   = 1;
  localparam int LampGrn   = 2;
  localparam int LampStart = 3;
  localparam int LampStop  = 4;
  localparam int LampJam   = 5;

  localparam logic [BlinkW-1:0] BlinkTicksReset = 16'd500;

  typedef logic [NumLamps-1:0] lamps_t;

  // Register indexes of the write port
  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_MODES    = 3'd0,
    REG_YELLOW_MODES = 3'd1,
    REG_GREEN_MODES  = 3'd2,
    REG_BLINK_TICKS  = 3'd3,
    REG_INIT_STATUS  = 3'd4
  } reg_idx_e;

  // Per-status tower lamp modes
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_FLICKER = 2'd2,
    MODE_HOLD    = 2'd3
  } lamp_mode_e;

  // Configuration bundle from the register file to the core
  typedef struct packed {
    logic [ModesW-1:0]  red_modes;
    logic [ModesW-1:0]  yellow_modes;
    logic [ModesW-1:0]  green_modes;
    logic [BlinkW-1:0]  blink_ticks;
    logic [StatusW-1:0] init_status_code;
  } cfg_t;

endpackage

// ----- design/tlbs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tlbs_cfg_regs: configuration registers
// Holds the mode tables, blink period and init status code; write-only port.
// ----------------------------------------------------------------------------
module tlbs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlbs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tlbs_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output tlbs_pkg::cfg_t                   cfg_o
);
  import tlbs_pkg::*;

  cfg_t cfg_q;

  // Decode the index and load the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_modes        <= '0;
      cfg_q.yellow_modes     <= '0;
      cfg_q.green_modes      <= '0;
      cfg_q.blink_ticks      <= BlinkTicksReset;
      cfg_q.init_status_code <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RED_MODES:    cfg_q.red_modes        <= cfg_wdata_i[ModesW-1:0];
        REG_YELLOW_MODES: cfg_q.yellow_modes     <= cfg_wdata_i[ModesW-1:0];
        REG_GREEN_MODES:  cfg_q.green_modes      <= cfg_wdata_i[ModesW-1:0];
        REG_BLINK_TICKS:  cfg_q.blink_ticks      <= cfg_wdata_i[BlinkW-1:0];
        REG_INIT_STATUS:  cfg_q.init_status_code <= cfg_wdata_i[StatusW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/tlbs_core.sv -----
// ----------------------------------------------------------------------------
// tlbs_core: blink phase sequencer and lamp update
// Four-phase loop (drive A, wait, drive B, wait) with a saturating tick
// counter; computes the new lamp levels for each accepted tick.
// ----------------------------------------------------------------------------
module tlbs_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [tlbs_pkg::StatusW-1:0]  equipment_status_i,
  input  logic                          recovery_request_i,
  input  logic                          io_debug_active_i,
  input  tlbs_pkg::cfg_t                cfg_i,
  output tlbs_pkg::lamps_t              lamps_o
);
  import tlbs_pkg::*;

  typedef enum logic [3:0] {
    PH_DRIVE_A = 4'b0001,
    PH_WAIT_A  = 4'b0010,
    PH_DRIVE_B = 4'b0100,
    PH_WAIT_B  = 4'b1000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [ElapsedW-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic                 odd_q, odd_d;
  lamps_t               lamps_q, lamps_d, drive_lamps;
  logic                 side_a, wait_done, is_init, in_table;
  lamp_mode_e           red_mode, yel_mode, grn_mode;

  // Level of a tower lamp after a drive phase
  function automatic logic tower_level(input logic cur, input lamp_mode_e mode,
                                       input logic a_side);
    logic lvl;
    lvl = cur;
    case (mode)
      MODE_OFF:     lvl = 1'b0;
      MODE_ON:      lvl = 1'b1;
      MODE_FLICKER: lvl = a_side;
      default:      lvl = cur;
    endcase
    return lvl;
  endfunction

  // Look up the per-status modes; statuses past the table leave lamps as they are
  assign in_table = int'(equipment_status_i) < StatusCount;
  assign red_mode = in_table ? lamp_mode_e'(cfg_i.red_modes[{equipment_status_i, 1'b0} +: 2])
                             : MODE_HOLD;
  assign yel_mode = in_table ? lamp_mode_e'(cfg_i.yellow_modes[{equipment_status_i, 1'b0} +: 2])
                             : MODE_HOLD;
  assign grn_mode = in_table ? lamp_mode_e'(cfg_i.green_modes[{equipment_status_i, 1'b0} +: 2])
                             : MODE_HOLD;

  assign side_a  = (phase_q == PH_DRIVE_A);
  assign is_init = (equipment_status_i == cfg_i.init_status_code);

  // Build the lamp word written by a drive phase
  always_comb begin
    drive_lamps = lamps_q;
    if (is_init) begin
      if (side_a) begin
        drive_lamps[LampStart] = odd_q;
        drive_lamps[LampStop]  = 1'b0;
        drive_lamps[LampJam]   = ~odd_q;
      end else begin
        drive_lamps[LampStart] = 1'b0;
        drive_lamps[LampStop]  = 1'b1;
        drive_lamps[LampJam]   = 1'b0;
      end
    end
    if (recovery_request_i) begin
      drive_lamps[LampStart] = side_a;
    end
    drive_lamps[LampRed] = tower_level(lamps_q[LampRed], red_mode, side_a);
    drive_lamps[LampYel] = tower_level(lamps_q[LampYel], yel_mode, side_a);
    drive_lamps[LampGrn] = tower_level(lamps_q[LampGrn], grn_mode, side_a);
  end

  // Saturating wait counter and its end condition
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + ElapsedW'(1);
  assign wait_done   = elapsed_inc > {1'b0, cfg_i.blink_ticks};

  // Advance the phase loop; debug freezes everything
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    odd_d     = odd_q;
    lamps_d   = lamps_q;
    if (!io_debug_active_i) begin
      unique case (phase_q)
        PH_DRIVE_A: begin
          lamps_d   = drive_lamps;
          elapsed_d = '0;
          phase_d   = PH_WAIT_A;
        end
        PH_WAIT_A: begin
          elapsed_d = elapsed_inc;
          if (wait_done) begin
            phase_d = PH_DRIVE_B;
          end
        end
        PH_DRIVE_B: begin
          lamps_d   = drive_lamps;
          elapsed_d = '0;
          phase_d   = PH_WAIT_B;
        end
        PH_WAIT_B: begin
          elapsed_d = elapsed_inc;
          if (wait_done) begin
            phase_d = PH_DRIVE_A;
            if (is_init) begin
              odd_d = ~odd_q;
            end
          end
        end
        default: phase_d = PH_DRIVE_A;
      endcase
    end
  end

  // Update state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DRIVE_A;
      elapsed_q <= '0;
      odd_q     <= 1'b1;
      lamps_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      odd_q     <= odd_d;
      lamps_q   <= lamps_d;
    end
  end

  assign lamps_o = lamps_d;

endmodule

// ----- design/tlbs_out_buf.sv -----
// ----------------------------------------------------------------------------
// tlbs_out_buf: result register with one-word skid stage
// Keeps the input side open while a finished word waits on the output.
// ----------------------------------------------------------------------------
module tlbs_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tlbs_pkg::lamps_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tlbs_pkg::lamps_t  out_word_o
);
  import tlbs_pkg::*;

  logic   out_valid_q, skid_valid_q;
  lamps_t out_q, skid_q;
  logic   accept, out_free;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Track occupancy of the output and skid slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Move words: skid drains first, otherwise the new word goes straight out
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= in_word_i;
      end
    end else if (accept) begin
      skid_q <= in_word_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- design/tower_lamp_blink_sequencer.sv -----
// ----------------------------------------------------------------------------
// tower_lamp_blink_sequencer: signal tower and switch lamp blink controller
// Top level: register file, phase sequencer and output buffer.
// ----------------------------------------------------------------------------
// Each accepted word is one time tick and yields exactly one lamp word. A new
// tick is taken every cycle while in_stall_o is low: the state update is a
// counter compare and a mode table mux between the input handshake and the
// result register, and a one-word skid stage keeps the input open while a
// result waits on a stalled output, so in_stall_o rises only after the output
// has been stalled with a word pending. Configuration writes take effect on
// the next cycle and are meant to be issued while no tick is in flight.
module tower_lamp_blink_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [tlbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tlbs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // tick input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlbs_pkg::StatusW-1:0]   equipment_status_i,
  input  logic                           recovery_request_i,
  input  logic                           io_debug_active_i,
  // lamp output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           red_lamp_o,
  output logic                           yellow_lamp_o,
  output logic                           green_lamp_o,
  output logic                           start_lamp_o,
  output logic                           stop_lamp_o,
  output logic                           jam_clear_lamp_o
);
  import tlbs_pkg::*;

  cfg_t   cfg;
  lamps_t next_lamps, out_lamps;
  logic   accept;

  assign accept = in_valid_i & ~in_stall_o;

  tlbs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tlbs_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .equipment_status_i (equipment_status_i),
    .recovery_request_i (recovery_request_i),
    .io_debug_active_i  (io_debug_active_i),
    .cfg_i              (cfg),
    .lamps_o            (next_lamps)
  );

  tlbs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (next_lamps),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_lamps)
  );

  // Break the lamp word out to its ports
  assign red_lamp_o       = out_lamps[LampRed];
  assign yellow_lamp_o    = out_lamps[LampYel];
  assign green_lamp_o     = out_lamps[LampGrn];
  assign start_lamp_o     = out_lamps[LampStart];
  assign stop_lamp_o      = out_lamps[LampStop];
  assign jam_clear_lamp_o = out_lamps[LampJam];

endmodule

// ----- design/tlbs_checker.sv -----
// ----------------------------------------------------------------------------
// tlbs_checker: port-level checks of the tower lamp blink sequencer
// Watches the handshakes on the top level and is bound to it below.
// ----------------------------------------------------------------------------
module tlbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic red_lamp_o,
  input logic yellow_lamp_o,
  input logic green_lamp_o,
  input logic start_lamp_o,
  input logic stop_lamp_o,
  input logic jam_clear_lamp_o
);

  // Input stall only while the output holds a word
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  // Input stall starts only after a stalled output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall raised without output back-pressure");

  // After every accepted tick the output holds a valid word on the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted tick produced no result word");

  // Stalled result word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(red_lamp_o) &&
      $stable(yellow_lamp_o) && $stable(green_lamp_o) && $stable(start_lamp_o) &&
      $stable(stop_lamp_o) && $stable(jam_clear_lamp_o)))
    else $error("stalled result word changed or dropped");

endmodule

bind tower_lamp_blink_sequencer tlbs_checker u_tlbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .red_lamp_o       (red_lamp_o),
  .yellow_lamp_o    (yellow_lamp_o),
  .green_lamp_o     (green_lamp_o),
  .start_lamp_o     (start_lamp_o),
  .stop_lamp_o      (stop_lamp_o),
  .jam_clear_lamp_o (jam_clear_lamp_o)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tower lamp blink sequencer
// Feeds tick words through the valid/stall input and predicts each lamp word
// with a cycle-free model of the phase loop, the lamp mode tables, the init
// switch pattern and the debug freeze. Runs a directed pass, then random
// ticks under several register settings with random and long output stalls.
// ----------------------------------------------------------------------------
module tb;
  import tlbs_pkg::*;

  localparam int HoldOffCycles = 80;
  localparam int HoldOffAt     = 350;
  localparam int StallLimit    = 1000;
  localparam int MaxReports    = 10;

  typedef enum logic [1:0] {
    SEQ_DRIVE_A = 2'd0,
    SEQ_WAIT_A  = 2'd1,
    SEQ_DRIVE_B = 2'd2,
    SEQ_WAIT_B  = 2'd3
  } seq_phase_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               recovery;
    logic               debug;
  } tick_t;

  // Clock, reset and block ports
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [StatusW-1:0]  eq_status = '0;
  logic                rec_req   = 1'b0;
  logic                dbg_on    = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                red_lamp, yellow_lamp, green_lamp;
  logic                start_lamp, stop_lamp, jam_lamp;

  // Predicted sequencer state and register copies
  seq_phase_e          seq_phase   = SEQ_DRIVE_A;
  logic [ElapsedW-1:0] elapsed_cnt = '0;
  logic                odd_loop    = 1'b1;
  lamps_t              lamp_lvl    = '0;
  logic [ModesW-1:0]   red_tbl     = '0;
  logic [ModesW-1:0]   yel_tbl     = '0;
  logic [ModesW-1:0]   grn_tbl     = '0;
  logic [BlinkW-1:0]   blink_len   = BlinkTicksReset;
  logic [StatusW-1:0]  init_code   = '0;

  tick_t  pending_ticks[$];
  lamps_t lamps_due[$];
  string  lamp_name[NumLamps] = '{"red", "yellow", "green", "start", "stop", "jam_clear"};

  int ticks_in     = 0;
  int words_out    = 0;
  int mismatches   = 0;
  int loop_flips   = 0;
  int frozen_ticks = 0;
  int quiet_cycles = 0;
  int idle_in_pct  = 21;
  int idle_out_pct = 57;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit in_fire      = 1'b0;

  tower_lamp_blink_sequencer DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .equipment_status_i (eq_status),
    .recovery_request_i (rec_req),
    .io_debug_active_i  (dbg_on),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .red_lamp_o         (red_lamp),
    .yellow_lamp_o      (yellow_lamp),
    .green_lamp_o       (green_lamp),
    .start_lamp_o       (start_lamp),
    .stop_lamp_o        (stop_lamp),
    .jam_clear_lamp_o   (jam_lamp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Look up the 2-bit mode of one status in a tower lamp table
  function automatic lamp_mode_e mode_for(logic [ModesW-1:0] tbl, logic [StatusW-1:0] status);
    if (int'(status) >= StatusCount) return MODE_HOLD;
    return lamp_mode_e'(tbl[2*status +: 2]);
  endfunction

  function automatic void set_tower(int idx, lamp_mode_e mode, logic side_a);
    case (mode)
      MODE_OFF:     lamp_lvl[idx] = 1'b0;
      MODE_ON:      lamp_lvl[idx] = 1'b1;
      MODE_FLICKER: lamp_lvl[idx] = side_a;
      default: ;
    endcase
  endfunction

  // Write all lamps for one drive phase and restart the wait count
  function automatic void drive_lamps(tick_t t, logic side_a);
    if (t.status == init_code) begin
      lamp_lvl[LampStart] = side_a & odd_loop;
      lamp_lvl[LampStop]  = ~side_a;
      lamp_lvl[LampJam]   = side_a & ~odd_loop;
    end
    if (t.recovery) lamp_lvl[LampStart] = side_a;
    set_tower(LampRed, mode_for(red_tbl, t.status), side_a);
    set_tower(LampYel, mode_for(yel_tbl, t.status), side_a);
    set_tower(LampGrn, mode_for(grn_tbl, t.status), side_a);
    elapsed_cnt = '0;
  endfunction

  // Count one wait tick, saturating, and report whether the wait is over
  function automatic logic wait_over();
    if (elapsed_cnt != '1) elapsed_cnt++;
    return elapsed_cnt > {1'b0, blink_len};
  endfunction

  // Advance the phase loop by one tick and return the lamp levels after it
  function automatic lamps_t advance_lamps(tick_t t);
    if (t.debug) begin
      frozen_ticks++;
    end else begin
      case (seq_phase)
        SEQ_DRIVE_A: begin
          drive_lamps(t, 1'b1);
          seq_phase = SEQ_WAIT_A;
        end
        SEQ_WAIT_A: begin
          if (wait_over()) seq_phase = SEQ_DRIVE_B;
        end
        SEQ_DRIVE_B: begin
          drive_lamps(t, 1'b0);
          seq_phase = SEQ_WAIT_B;
        end
        default: begin
          if (wait_over()) begin
            seq_phase = SEQ_DRIVE_A;
            if (t.status == init_code) begin
              odd_loop = ~odd_loop;
              loop_flips++;
            end
          end
        end
      endcase
    end
    return lamp_lvl;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RED_MODES:    red_tbl   = val;
      REG_YELLOW_MODES: yel_tbl   = val;
      REG_GREEN_MODES:  grn_tbl   = val;
      REG_BLINK_TICKS:  blink_len = val[BlinkW-1:0];
      default:          init_code = val[StatusW-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [ModesW-1:0] red, logic [ModesW-1:0] yel,
                               logic [ModesW-1:0] grn, logic [BlinkW-1:0] blink,
                               logic [StatusW-1:0] init);
    write_reg(REG_RED_MODES, red);
    write_reg(REG_YELLOW_MODES, yel);
    write_reg(REG_GREEN_MODES, grn);
    write_reg(REG_BLINK_TICKS, CfgDataW'(blink));
    write_reg(REG_INIT_STATUS, CfgDataW'(init));
  endtask

  task automatic queue_tick(int status, bit recovery, bit debug);
    tick_t t;
    t.status   = StatusW'(status);
    t.recovery = recovery;
    t.debug    = debug;
    pending_ticks.push_back(t);
  endtask

  // Random ticks, biased toward the init status so the switch pattern runs
  task automatic queue_random(int n);
    tick_t t;
    repeat (n) begin
      t.status   = ($urandom_range(0, 99) < 45) ? init_code
                                                : StatusW'($urandom_range(0, 15));
      t.recovery = ($urandom_range(0, 3) == 0);
      t.debug    = ($urandom_range(0, 11) == 0);
      pending_ticks.push_back(t);
    end
  endtask

  // Wait until every tick is taken and every lamp word has come back;
  // look just after the falling edge so the driver's update is visible
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_ticks.size() > 0 || in_valid || lamps_due.size() > 0);
    repeat (3) @(negedge clk);
  endtask

  // Offer the next tick word once the current one is taken
  always @(negedge clk) begin : drive_ticks
    tick_t nxt;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= idle_in_pct) begin
        nxt = pending_ticks.pop_front();
        in_valid  <= 1'b1;
        eq_status <= nxt.status;
        rec_req   <= nxt.recovery;
        dbg_on    <= nxt.debug;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the lamp output at random, with one long hold while ticks keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && ticks_in >= HoldOffAt) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_out_pct);
    end
  end

  // Predict on each taken tick, compare each delivered lamp word, watch for hangs
  always @(posedge clk) begin : check_lamps
    tick_t  t;
    lamps_t want;
    lamps_t got;
    if (rst_n) begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        t.status   = eq_status;
        t.recovery = rec_req;
        t.debug    = dbg_on;
        lamps_due.push_back(advance_lamps(t));
        ticks_in++;
      end
      if (out_valid && !out_stall) begin
        got = {jam_lamp, stop_lamp, start_lamp, green_lamp, yellow_lamp, red_lamp};
        words_out++;
        if (lamps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) $display("unexpected lamp word %b", got);
        end else begin
          want = lamps_due.pop_front();
          for (int k = 0; k < NumLamps; k++) begin
            if (got[k] !== want[k]) begin
              mismatches++;
              if (mismatches <= MaxReports)
                $display("lamp word %0d: %s expected %b got %b",
                         words_out, lamp_name[k], want[k], got[k]);
            end
          end
        end
      end
      if (in_fire || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("no word moved for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: all tower lamps off, init status zero, long period
    queue_random(16);
    drain();

    // Directed: every mode, both init loops, recovery, debug freeze, zero period
    apply_setting(32'hE4E4_E4E4, 32'h1B1B_1B1B, 32'hAAAA_5555, 16'd0, 4'd0);
    queue_tick(0, 0, 0); queue_tick(0, 0, 0); queue_tick(0, 0, 0); queue_tick(0, 0, 0);
    queue_tick(0, 0, 0); queue_tick(2, 0, 0); queue_tick(2, 0, 0); queue_tick(0, 0, 0);
    queue_tick(1, 1, 0); queue_tick(1, 0, 1); queue_tick(1, 0, 1); queue_tick(15, 0, 0);
    queue_tick(15, 1, 0); queue_tick(5, 0, 0);
    queue_tick(3, 0, 0); queue_tick(3, 0, 0); queue_tick(0, 1, 0); queue_tick(0, 0, 0);
    queue_tick(14, 0, 0); queue_tick(0, 0, 1); queue_tick(8, 0, 0); queue_tick(15, 0, 0);
    queue_tick(0, 0, 0);
    drain();

    // Random phases, sender idles lightly and receiver heavily
    apply_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 16'd1, 4'd15);
    queue_random(200);
    drain();
    apply_setting($urandom, $urandom, $urandom, 16'd0, StatusW'($urandom_range(0, 15)));
    queue_random(200);
    drain();
    apply_setting(32'h5555_5555, $urandom, $urandom, 16'd3, 4'd0);
    queue_random(200);
    drain();

    // Swap the idling of the two sides
    idle_in_pct  = 57;
    idle_out_pct = 21;
    apply_setting($urandom, $urandom, $urandom, 16'hFFFF, 4'd7);
    queue_random(120);
    drain();
    apply_setting($urandom, $urandom, $urandom, BlinkW'($urandom_range(0, 6)),
                  StatusW'($urandom_range(0, 15)));
    queue_random(200);
    drain();
    apply_setting($urandom, $urandom, $urandom, 16'd12, StatusW'($urandom_range(0, 15)));
    queue_random(200);
    drain();

    // Full rate on both sides
    idle_in_pct  = 0;
    idle_out_pct = 0;
    apply_setting($urandom, $urandom, $urandom, 16'd2, 4'd15);
    queue_random(200);
    drain();
    apply_setting($urandom, $urandom, $urandom, 16'd0, 4'd0);
    queue_random(200);
    drain();

    $display("Run covered %0d ticks and %0d lamp words over ten register settings,",
             ticks_in, words_out);
    $display("with %0d frozen ticks, %0d init loop toggles and a %0d-cycle output hold.",
             frozen_ticks, loop_flips, HoldOffCycles);
    if (mismatches == 0 && lamps_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
